@@ src/brte_pkg.sv @@
package brte_pkg;

    localparam logic [7:0] BLANK_CODE   = 8'd32;
    localparam logic [7:0] TAB_CODE     = 8'd9;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [4:0] DEFAULT_TAB_WIDTH = 5'd8;
    localparam logic [4:0] MIN_TAB_WIDTH = 5'd2;
    localparam logic [4:0] MAX_TAB_WIDTH = 5'd16;
    localparam logic [4:0] MAX_PENDING_SAT = 5'd31;
    localparam logic [3:0] MAX_FLUSH = 4'd15;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic accept;  // take the input byte and update the line state
        logic emit;    // push the next flush result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic in_blank;   // input byte is a blank
        logic pend_zero;  // no blanks pending before this byte
        logic cnt_zero;   // flush has no blanks left, only the held byte
    } t_dp_stat;

endpackage

@@ src/blank_run_to_tab_encoder_top.sv @@
// A result is registered on the master side in the cycle after its input transaction;
// results of a flush come from the flush state instead; a blank may give no result.
// Throughput: one byte per cycle while no blanks are pending and the output is free;
// a non-blank byte after k pending blanks (k capped at 15) gives k+1 results, one per
// cycle through the single output register when taken, and holds the slave side meanwhile.
// Reset (i_rst_n low, synchronous): state clears, tab width returns to 8, output empties.
module blank_run_to_tab_encoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,  // tab_width
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic       o_m_tlast     // last
);
    import brte_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    brte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    brte_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_byte   (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_byte  (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

endmodule

@@ src/brte_ctrl.sv @@
module brte_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  brte_pkg::t_dp_stat i_stat,
    output brte_pkg::t_dp_cmd  o_cmd
);
    import brte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = i_stat.out_free;
                if (i_s_tvalid && i_stat.out_free) begin
                    o_cmd.accept = 1'b1;
                    // a non-blank behind pending blanks needs a flush
                    if (!i_stat.in_blank && !i_stat.pend_zero) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.cnt_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/brte_dp.sv @@
module brte_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic [7:0]         i_in_byte,
    input  brte_pkg::t_dp_cmd  i_cmd,
    output brte_pkg::t_dp_stat o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_out_last
);
    import brte_pkg::*;

    logic [4:0] r_tab_width;
    logic [3:0] r_column;
    logic [4:0] r_pending;
    logic [1:0] r_run;
    logic [3:0] r_cnt;
    logic [7:0] r_hold;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [3:0] n_column;
    logic [4:0] n_pending;
    logic [1:0] n_run;
    logic       n_load;
    logic [7:0] n_out_byte;
    logic       n_out_last;

    logic [4:0] eff_width;
    logic [4:0] col_inc;
    logic [3:0] col_adv;
    logic       is_blank;
    logic       first_tab;
    logic       second_tab;
    logic [4:0] pend_mid;
    logic [3:0] flush_cnt;

    assign is_blank = (i_in_byte == BLANK_CODE);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.in_blank  = is_blank;
    assign o_stat.pend_zero = (r_pending == 5'd0);
    assign o_stat.cnt_zero  = (r_cnt == 4'd0);

    always_comb begin
        priority if (r_tab_width < MIN_TAB_WIDTH) begin
            eff_width = MIN_TAB_WIDTH;
        end else if (r_tab_width > MAX_TAB_WIDTH) begin
            eff_width = MAX_TAB_WIDTH;
        end else begin
            eff_width = r_tab_width;
        end
    end

    // wrap to zero at the tab stop, also when the width shrank under the column
    assign col_inc = {1'b0, r_column} + 5'd1;
    assign col_adv = (col_inc >= eff_width) ? 4'd0 : col_inc[3:0];

    assign flush_cnt = (r_pending > {1'b0, MAX_FLUSH}) ? MAX_FLUSH : r_pending[3:0];

    always_comb begin
        first_tab  = (r_run == 2'd1) && (r_column == 4'd0) && (r_pending != 5'd0);
        pend_mid   = first_tab ? 5'd0 : r_pending;
        n_run      = (r_run < 2'd2) ? r_run + 2'd1 : r_run;
        pend_mid   = (pend_mid < MAX_PENDING_SAT) ? pend_mid + 5'd1 : pend_mid;
        n_column   = col_adv;
        second_tab = (n_run == 2'd2) && (col_adv == 4'd0);
        n_pending  = second_tab ? 5'd0 : pend_mid;
        n_load     = first_tab || second_tab;
        n_out_byte = TAB_CODE;
        n_out_last = 1'b1;
        if (!is_blank) begin
            n_run      = 2'd0;
            n_pending  = 5'd0;
            n_column   = (i_in_byte == NEWLINE_CODE) ? 4'd0 : col_adv;
            n_load     = (flush_cnt == 4'd0);
            n_out_byte = i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= DEFAULT_TAB_WIDTH;
            r_column    <= '0;
            r_pending   <= '0;
            r_run       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tab_width <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_column  <= n_column;
                r_pending <= n_pending;
                r_run     <= n_run;
                if (!is_blank) begin
                    r_cnt <= flush_cnt;
                end
            end else if (i_cmd.emit && (r_cnt != 4'd0)) begin
                r_cnt <= r_cnt - 4'd1;
            end
            if ((i_cmd.accept && n_load) || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hold <= i_in_byte;
            if (n_load) begin
                r_out_byte <= n_out_byte;
                r_out_last <= n_out_last;
            end
        end else if (i_cmd.emit) begin
            if (r_cnt != 4'd0) begin
                r_out_byte <= BLANK_CODE;
                r_out_last <= 1'b0;
            end else begin
                r_out_byte <= r_hold;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

@@ src/brte_chk.sv @@
module brte_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);
    import brte_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // only flushed blanks are followed by more results of the same byte
    a_mid_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata == BLANK_CODE)
        else $error("non-final result is not a blank");

    a_tab_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata == TAB_CODE |-> o_m_tlast)
        else $error("tab not final result");

    // no new byte taken while a flush is under way
    a_no_accept_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input ready during flush");

endmodule

bind blank_run_to_tab_encoder_top brte_chk u_brte_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import brte_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BYTES    = 35;

    localparam int READY_ALWAYS = 0;
    localparam int READY_HALF   = 1;
    localparam int READY_SPARSE = 2;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_out_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_wdata = '0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = '0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;

    // text bytes waiting for the driver, encoder output still owed by the block
    logic [7:0] text_q[$];
    t_out_byte  expected_out_q[$];

    // line state of the predictor
    logic [4:0] pred_tab_width = DEFAULT_TAB_WIDTH;
    logic [3:0] pred_column = '0;
    logic [4:0] pred_pending = '0;
    logic [1:0] pred_run = '0;

    int   mismatches = 0;
    int   quiet_cycles = 0;
    logic byte_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_mode = READY_ALWAYS;
    int   stall_span = 0;

    blank_run_to_tab_encoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Work out the encoder output for one accepted text byte and queue it.
    task automatic entab_predict(input logic [7:0] b);
        int         width;
        int         flush;
        logic [7:0] codes[$];
        t_out_byte  item;
        width = (pred_tab_width < MIN_TAB_WIDTH) ? int'(MIN_TAB_WIDTH) :
                (pred_tab_width > MAX_TAB_WIDTH) ? int'(MAX_TAB_WIDTH) : int'(pred_tab_width);
        if (b == BLANK_CODE) begin
            // first blank of the run sat on a stop: the second one turns it into a tab
            if (pred_run == 2'd1 && pred_column == 4'd0 && pred_pending != 5'd0) begin
                codes.push_back(TAB_CODE);
                pred_pending = '0;
            end
            if (pred_run < 2'd2)
                pred_run = pred_run + 2'd1;
            if (pred_pending < MAX_PENDING_SAT)
                pred_pending = pred_pending + 5'd1;
            pred_column = (int'(pred_column) + 1 >= width) ? 4'd0 : pred_column + 4'd1;
            if (pred_run >= 2'd2 && pred_column == 4'd0) begin
                codes.push_back(TAB_CODE);
                pred_pending = '0;
            end
        end else begin
            flush = (pred_pending > 5'(MAX_FLUSH)) ? int'(MAX_FLUSH) : int'(pred_pending);
            repeat (flush) codes.push_back(BLANK_CODE);
            codes.push_back(b);
            pred_pending = '0;
            pred_run = '0;
            if (b == NEWLINE_CODE)
                pred_column = '0;
            else
                pred_column = (int'(pred_column) + 1 >= width) ? 4'd0 : pred_column + 4'd1;
        end
        foreach (codes[i]) begin
            item.code = codes[i];
            item.last = (i == codes.size() - 1);
            expected_out_q.push_back(item);
        end
    endtask

    // Monitor: sample both sides, predict, check, and watch for a hang.
    always @(posedge i_clk) begin
        t_out_byte want;
        byte_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            pred_tab_width = DEFAULT_TAB_WIDTH;
            pred_column = '0;
            pred_pending = '0;
            pred_run = '0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_out_q.size() == 0) begin
                    report($sformatf("unexpected output byte %0d last %0b", o_m_tdata, o_m_tlast));
                end else begin
                    want = expected_out_q.pop_front();
                    if (o_m_tdata !== want.code)
                        report($sformatf("out_byte %0d, want %0d", o_m_tdata, want.code));
                    if (o_m_tlast !== want.last)
                        report($sformatf("last %0b on byte %0d, want %0b",
                                         o_m_tlast, o_m_tdata, want.last));
                end
            end
            if (i_s_tvalid && o_s_tready)
                entab_predict(i_s_tdata);
            if (i_cfg_we)
                pred_tab_width = i_cfg_wdata;
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || byte_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (text_q.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= text_q.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure: switch between stall patterns after spans of random length.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
            stall_span = $urandom_range(20, 80);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            READY_ALWAYS: i_m_tready <= 1'b1;
            READY_HALF:   i_m_tready <= 1'($urandom_range(0, 1));
            default:      i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic queue_bytes(input logic [7:0] b, input int count);
        repeat (count) text_q.push_back(b);
    endtask

    // Random text: blank runs of varied length, words, tabs and line ends.
    task automatic queue_random_text(input int count);
        int added;
        int pick;
        int len;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 4);
                queue_bytes(BLANK_CODE, len);
            end else if (pick < 50) begin
                len = 1;
                queue_bytes(NEWLINE_CODE, 1);
            end else if (pick < 55) begin
                len = 1;
                queue_bytes(TAB_CODE, 1);
            end else begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 4) == 0)
                        text_q.push_back(8'($urandom_range(0, 255)));
                    else
                        text_q.push_back(8'($urandom_range(33, 126)));
                end
            end
            added += len;
        end
    endtask

    // Hold until every byte is sent and every output byte has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        while (text_q.size() != 0 || i_s_tvalid || expected_out_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tab_width(input logic [4:0] w);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [4:0] widths[$];

        // lone blank, blank run reaching a stop, trailing blanks flushed before newline
        queue_bytes(8'h61, 1);
        queue_bytes(BLANK_CODE, 1);
        queue_bytes(8'h62, 1);
        queue_bytes(BLANK_CODE, 7);
        queue_bytes(8'h78, 1);
        queue_bytes(BLANK_CODE, 2);
        queue_bytes(NEWLINE_CODE, 1);
        // byte extremes and an input tab
        queue_bytes(8'h00, 1);
        queue_bytes(8'hFF, 1);
        queue_bytes(TAB_CODE, 1);
        // first blank of a run lands on a stop, second blank follows
        queue_bytes(8'h41, 4);
        queue_bytes(BLANK_CODE, 2);
        queue_bytes(8'h7A, 1);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        widths = '{5'd2, 5'd16, 5'd0, 5'd1, 5'd31, 5'd17, 5'd3,
                   5'($urandom_range(0, 31)), DEFAULT_TAB_WIDTH};
        foreach (widths[i]) begin
            write_tab_width(widths[i]);
            queue_random_text(PHASE_BYTES);
            wait_idle();
        end

        if (expected_out_q.size() != 0)
            report($sformatf("%0d output bytes never arrived", expected_out_q.size()));
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/brte_pkg.sv
src/brte_ctrl.sv
src/brte_dp.sv
src/blank_run_to_tab_encoder_top.sv
src/brte_chk.sv
dv/tb.sv
